>>> hw/rtl/cell_bucket_grouping_top_assert.svh
// Assertion macros for the cell bucket grouping block.
`ifndef CELL_BUCKET_GROUPING_TOP_ASSERT_SVH
`define CELL_BUCKET_GROUPING_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define CBG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define CBG_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define CBG_ASSERT_IMPL(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cbg_pkg.sv
// Package with the shared constants and the function code type of the cell bucket grouping block.
`timescale 1ns / 1ps
package cbg_pkg;

  localparam int unsigned MAX_AGENTS_DEF = 1024;
  localparam int unsigned NUM_CELLS_DEF  = 256;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned ID_W       = 10;
  localparam int unsigned CELL_REQ_W = 8;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned RANGE_W    = 10;
  localparam int unsigned TOTAL_W    = 11;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD       = 2'd0,
    FUNC_BUILD      = 2'd1,
    FUNC_READ_SLOT  = 2'd2,
    FUNC_READ_RANGE = 2'd3
  } func_e;

endpackage

>>> hw/rtl/cell_bucket_grouping_top.sv
// Top level of the cell bucket grouping block: stable counting sort of agent ids by grid cell.
`timescale 1ns / 1ps
`include "cell_bucket_grouping_top_assert.svh"
// Usage: items arrive on the input channel (in_valid_i, in_stall_o) with func_i choosing a load,
// a build, a sorted slot read or a cell range read; every item gives exactly one result transfer
// on the output channel (out_valid_o, out_stall_i).
// Loads and reads are taken one per cycle while in_stall_o is low; their result passes through
// the holding stage and then the output register before its transfer. The memory read of a
// query lands in the holding stage, so the next item is taken while a finished result still
// waits in the output register.
// A build walks the memories and holds in_stall_o high while it runs: it clears the fill
// counts cell by cell, counts the pairs per cell, turns the counts into first slots by a prefix
// sum and places the ids pair by pair, the last three passes paced by the single read port of
// the fill count memory. Its result (the number of pairs grouped) follows at the end of the walk.
// After reset the load count and the sorted total are zero and every cell reads as empty; the
// pair and sorted id memories are not cleared and their contents are used only below those counts.
// When the receiver stalls, the output register holds its result, one further item may enter
// the holding stage, and then the input channel stalls as well.
module cell_bucket_grouping_top #(
  parameter int unsigned MAX_AGENTS = cbg_pkg::MAX_AGENTS_DEF,
  parameter int unsigned NUM_CELLS  = cbg_pkg::NUM_CELLS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cbg_pkg::FUNC_W-1:0]     func_i,
  input  logic [cbg_pkg::ID_W-1:0]       agent_id_i,
  input  logic [cbg_pkg::CELL_REQ_W-1:0] cell_req_i,
  input  logic [cbg_pkg::SLOT_W-1:0]     slot_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cbg_pkg::ID_W-1:0]       id_out_o,
  output logic [cbg_pkg::RANGE_W-1:0]    range_first_o,
  output logic [cbg_pkg::RANGE_W-1:0]    range_last_o,
  output logic                           present_o,
  output logic [cbg_pkg::TOTAL_W-1:0]    total_o,
  output logic                           overflow_o
);
  import cbg_pkg::*;

  localparam int unsigned AW       = $clog2(MAX_AGENTS);
  localparam int unsigned CNT_W    = $clog2(MAX_AGENTS + 1);
  localparam int unsigned CELL_W   = $clog2(NUM_CELLS);
  localparam int unsigned CIDX_W   = $clog2(NUM_CELLS + 1);
  localparam int unsigned PAIR_W   = CELL_W + ID_W;
  localparam int unsigned RENT_W   = 1 + 2 * CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_COUNT,
    ST_PREFIX,
    ST_PLACE,
    ST_FINISH
  } state_e;

  // Memories.
  logic [PAIR_W-1:0] pair_mem   [MAX_AGENTS];
  logic [ID_W-1:0]   sorted_mem [MAX_AGENTS];
  logic [CNT_W-1:0]  fill_mem   [NUM_CELLS];
  logic [RENT_W-1:0] range_mem  [NUM_CELLS];

  logic              pair_we, pair_re;
  logic [AW-1:0]     pair_waddr, pair_raddr;
  logic [PAIR_W-1:0] pair_wdata, pair_rd_q;

  logic              sorted_we, sorted_re;
  logic [AW-1:0]     sorted_waddr, sorted_raddr;
  logic [ID_W-1:0]   sorted_wdata, sorted_rd_q;

  logic              fill_we, fill_re;
  logic [CELL_W-1:0] fill_waddr, fill_raddr;
  logic [CNT_W-1:0]  fill_wdata, fill_rd_q;

  logic              range_we, range_re;
  logic [CELL_W-1:0] range_waddr, range_raddr;
  logic [RENT_W-1:0] range_wdata, range_rd_q;

  // Control and datapath registers.
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   load_count_q, load_count_d;
  logic [CNT_W-1:0]   sorted_total_q, sorted_total_d;
  logic               built_q, built_d;
  logic [CNT_W-1:0]   ent_idx_q, ent_idx_d;
  logic [CIDX_W-1:0]  cell_idx_q, cell_idx_d;
  logic [CNT_W-1:0]   next_q, next_d;
  logic               a_v_q, a_v_d;
  logic               b_v_q, b_v_d;
  logic [CELL_W-1:0]  b_cell_q, b_cell_d;
  logic [ID_W-1:0]    b_id_q, b_id_d;
  logic               fwd_q, fwd_d;
  logic [CNT_W-1:0]   fwd_data_q, fwd_data_d;

  logic               p1_valid_q, p1_valid_d;
  func_e              p1_func_q, p1_func_d;
  logic [TOTAL_W-1:0] p1_total_q, p1_total_d;
  logic               p1_ovf_q, p1_ovf_d;
  logic               p1_hit_q, p1_hit_d;

  logic               out_valid_q, out_valid_d;
  logic [ID_W-1:0]    out_id_q, out_id_d;
  logic [RANGE_W-1:0] out_first_q, out_first_d;
  logic [RANGE_W-1:0] out_last_q, out_last_d;
  logic               out_present_q, out_present_d;
  logic [TOTAL_W-1:0] out_total_q, out_total_d;
  logic               out_ovf_q, out_ovf_d;

  func_e             in_func;
  logic              in_accept;
  logic              out_blocked;
  logic              cell_ok;
  logic              store_full;
  logic              slot_hit;
  logic              range_hit;
  logic [CELL_W-1:0] pair_cell;
  logic [ID_W-1:0]   pair_id;
  logic [CNT_W-1:0]  cur_fill;

  assign in_func     = func_e'(func_i);
  assign out_blocked = out_valid_q && out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) || (p1_valid_q && out_blocked);
  assign in_accept   = in_valid_i && !in_stall_o;

  assign cell_ok    = 32'(cell_req_i) < NUM_CELLS;
  assign store_full = load_count_q == CNT_W'(MAX_AGENTS);
  assign slot_hit   = 32'(slot_i) < 32'(sorted_total_q);
  assign range_hit  = p1_hit_q && !range_rd_q[RENT_W-1];

  assign pair_cell = pair_rd_q[PAIR_W-1:ID_W];
  assign pair_id   = pair_rd_q[ID_W-1:0];
  // The fill count written in the previous cycle is not yet visible at the read port.
  assign cur_fill  = fwd_q ? fwd_data_q : fill_rd_q;

  always_comb begin
    state_d        = state_q;
    load_count_d   = load_count_q;
    sorted_total_d = sorted_total_q;
    built_d        = built_q;
    ent_idx_d      = ent_idx_q;
    cell_idx_d     = cell_idx_q;
    next_d         = next_q;
    a_v_d          = 1'b0;
    b_v_d          = 1'b0;
    b_cell_d       = b_cell_q;
    b_id_d         = b_id_q;
    fwd_d          = 1'b0;
    fwd_data_d     = fwd_data_q;

    p1_valid_d = p1_valid_q;
    p1_func_d  = p1_func_q;
    p1_total_d = p1_total_q;
    p1_ovf_d   = p1_ovf_q;
    p1_hit_d   = p1_hit_q;

    out_valid_d   = out_valid_q;
    out_id_d      = out_id_q;
    out_first_d   = out_first_q;
    out_last_d    = out_last_q;
    out_present_d = out_present_q;
    out_total_d   = out_total_q;
    out_ovf_d     = out_ovf_q;

    pair_we      = 1'b0;
    pair_waddr   = '0;
    pair_wdata   = '0;
    pair_re      = 1'b0;
    pair_raddr   = '0;
    sorted_we    = 1'b0;
    sorted_waddr = '0;
    sorted_wdata = '0;
    sorted_re    = 1'b0;
    sorted_raddr = '0;
    fill_we      = 1'b0;
    fill_waddr   = '0;
    fill_wdata   = '0;
    fill_re      = 1'b0;
    fill_raddr   = '0;
    range_we     = 1'b0;
    range_waddr  = '0;
    range_wdata  = '0;
    range_re     = 1'b0;
    range_raddr  = '0;

    // Output register takes the holding stage whenever it is free or being drained.
    if (!out_blocked) begin
      out_valid_d   = p1_valid_q;
      out_id_d      = '0;
      out_first_d   = '0;
      out_last_d    = '0;
      out_present_d = 1'b0;
      out_total_d   = p1_total_q;
      out_ovf_d     = 1'b0;
      unique case (p1_func_q)
        FUNC_LOAD: begin
          out_ovf_d = p1_ovf_q;
        end
        FUNC_BUILD: begin
        end
        FUNC_READ_SLOT: begin
          out_present_d = p1_hit_q;
          out_id_d      = p1_hit_q ? sorted_rd_q : '0;
        end
        FUNC_READ_RANGE: begin
          out_present_d = range_hit;
          out_first_d   = range_hit ? RANGE_W'(range_rd_q[2*CNT_W-1:CNT_W]) : '0;
          out_last_d    = range_hit ? RANGE_W'(range_rd_q[CNT_W-1:0]) : '0;
        end
      endcase
      p1_valid_d = 1'b0;
    end

    // Holding stage: loads finish here, queries wait here for their memory read.
    if (in_accept) begin
      p1_valid_d = in_func != FUNC_BUILD;
      p1_func_d  = in_func;
      p1_total_d = TOTAL_W'(sorted_total_q);
      p1_ovf_d   = 1'b0;
      p1_hit_d   = 1'b0;
      unique case (in_func)
        FUNC_LOAD: begin
          if (store_full) begin
            p1_ovf_d = 1'b1;
          end else if (cell_ok) begin
            pair_we      = 1'b1;
            pair_waddr   = load_count_q[AW-1:0];
            pair_wdata   = {CELL_W'(cell_req_i), agent_id_i};
            load_count_d = load_count_q + 1'b1;
          end
          p1_total_d = TOTAL_W'(load_count_d);
        end
        FUNC_BUILD: begin
          state_d    = ST_CLEAR;
          cell_idx_d = '0;
        end
        FUNC_READ_SLOT: begin
          sorted_re    = 1'b1;
          sorted_raddr = AW'(slot_i);
          p1_hit_d     = slot_hit;
        end
        FUNC_READ_RANGE: begin
          range_re    = 1'b1;
          range_raddr = CELL_W'(cell_req_i);
          p1_hit_d    = cell_ok && built_q;
        end
      endcase
    end

    // Build sequencer.
    unique case (state_q) inside
      ST_IDLE: begin
      end
      ST_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = cell_idx_q[CELL_W-1:0];
        fill_wdata = '0;
        cell_idx_d = cell_idx_q + 1'b1;
        if (cell_idx_q == CIDX_W'(NUM_CELLS - 1)) begin
          state_d   = ST_COUNT;
          ent_idx_d = '0;
        end
      end
      ST_COUNT, ST_PLACE: begin
        // Three steps per pair: read the pair, read its cell's fill count, write it back.
        if (ent_idx_q != load_count_q) begin
          pair_re    = 1'b1;
          pair_raddr = ent_idx_q[AW-1:0];
          ent_idx_d  = ent_idx_q + 1'b1;
          a_v_d      = 1'b1;
        end
        if (a_v_q) begin
          fill_re    = 1'b1;
          fill_raddr = pair_cell;
          b_v_d      = 1'b1;
          b_cell_d   = pair_cell;
          b_id_d     = pair_id;
          fwd_d      = b_v_q && (pair_cell == b_cell_q);
        end
        fwd_data_d = cur_fill + 1'b1;
        if (b_v_q) begin
          fill_we    = 1'b1;
          fill_waddr = b_cell_q;
          fill_wdata = cur_fill + 1'b1;
          if (state_q == ST_PLACE) begin
            sorted_we    = 1'b1;
            sorted_waddr = cur_fill[AW-1:0];
            sorted_wdata = b_id_q;
          end
        end
        if ((ent_idx_q == load_count_q) && !a_v_q && !b_v_q) begin
          if (state_q == ST_COUNT) begin
            state_d    = ST_PREFIX;
            cell_idx_d = '0;
            next_d     = '0;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_PREFIX: begin
        // Turn each count into the cell's first slot and record its range.
        if (cell_idx_q != CIDX_W'(NUM_CELLS)) begin
          fill_re    = 1'b1;
          fill_raddr = cell_idx_q[CELL_W-1:0];
          b_v_d      = 1'b1;
          b_cell_d   = cell_idx_q[CELL_W-1:0];
          cell_idx_d = cell_idx_q + 1'b1;
        end
        if (b_v_q) begin
          range_we    = 1'b1;
          range_waddr = b_cell_q;
          if (fill_rd_q == '0) begin
            range_wdata = {1'b1, {(2 * CNT_W){1'b0}}};
          end else begin
            range_wdata = {1'b0, next_q, CNT_W'(next_q + fill_rd_q - 1'b1)};
          end
          fill_we    = 1'b1;
          fill_waddr = b_cell_q;
          fill_wdata = next_q;
          next_d     = next_q + fill_rd_q;
        end
        if ((cell_idx_q == CIDX_W'(NUM_CELLS)) && !b_v_q) begin
          state_d   = ST_PLACE;
          ent_idx_d = '0;
        end
      end
      ST_FINISH: begin
        if (!p1_valid_q) begin
          p1_valid_d     = 1'b1;
          p1_func_d      = FUNC_BUILD;
          p1_total_d     = TOTAL_W'(load_count_q);
          p1_ovf_d       = 1'b0;
          p1_hit_d       = 1'b0;
          sorted_total_d = load_count_q;
          load_count_d   = '0;
          built_d        = 1'b1;
          state_d        = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      load_count_q   <= '0;
      sorted_total_q <= '0;
      built_q        <= 1'b0;
      ent_idx_q      <= '0;
      cell_idx_q     <= '0;
      next_q         <= '0;
      a_v_q          <= 1'b0;
      b_v_q          <= 1'b0;
      b_cell_q       <= '0;
      b_id_q         <= '0;
      fwd_q          <= 1'b0;
      fwd_data_q     <= '0;
      p1_valid_q     <= 1'b0;
      p1_func_q      <= FUNC_LOAD;
      p1_total_q     <= '0;
      p1_ovf_q       <= 1'b0;
      p1_hit_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      out_id_q       <= '0;
      out_first_q    <= '0;
      out_last_q     <= '0;
      out_present_q  <= 1'b0;
      out_total_q    <= '0;
      out_ovf_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      load_count_q   <= load_count_d;
      sorted_total_q <= sorted_total_d;
      built_q        <= built_d;
      ent_idx_q      <= ent_idx_d;
      cell_idx_q     <= cell_idx_d;
      next_q         <= next_d;
      a_v_q          <= a_v_d;
      b_v_q          <= b_v_d;
      b_cell_q       <= b_cell_d;
      b_id_q         <= b_id_d;
      fwd_q          <= fwd_d;
      fwd_data_q     <= fwd_data_d;
      p1_valid_q     <= p1_valid_d;
      p1_func_q      <= p1_func_d;
      p1_total_q     <= p1_total_d;
      p1_ovf_q       <= p1_ovf_d;
      p1_hit_q       <= p1_hit_d;
      out_valid_q    <= out_valid_d;
      out_id_q       <= out_id_d;
      out_first_q    <= out_first_d;
      out_last_q     <= out_last_d;
      out_present_q  <= out_present_d;
      out_total_q    <= out_total_d;
      out_ovf_q      <= out_ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pair_mem[pair_waddr] <= pair_wdata;
    end
    if (pair_re) begin
      pair_rd_q <= pair_mem[pair_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sorted_we) begin
      sorted_mem[sorted_waddr] <= sorted_wdata;
    end
    if (sorted_re) begin
      sorted_rd_q <= sorted_mem[sorted_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (fill_re) begin
      fill_rd_q <= fill_mem[fill_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (range_we) begin
      range_mem[range_waddr] <= range_wdata;
    end
    if (range_re) begin
      range_rd_q <= range_mem[range_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign id_out_o      = out_id_q;
  assign range_first_o = out_first_q;
  assign range_last_o  = out_last_q;
  assign present_o     = out_present_q;
  assign total_o       = out_total_q;
  assign overflow_o    = out_ovf_q;

  `CBG_ASSERT_ALWAYS(a_load_count_bound, load_count_q <= CNT_W'(MAX_AGENTS), "load count beyond capacity")
  `CBG_ASSERT_NEXT(a_build_starts, in_accept && (in_func == FUNC_BUILD), state_q == ST_CLEAR, "build did not start the clearing pass")
  `CBG_ASSERT_IMPL(a_fwd_in_walk, fwd_q, (state_q == ST_COUNT) || (state_q == ST_PLACE), "fill forwarding outside a pair walk")
  `CBG_ASSERT_NEXT(a_finish_clears, (state_q == ST_FINISH) && !p1_valid_q, (load_count_q == '0) && (state_q == ST_IDLE), "build end did not clear the load count")

endmodule
